// File: src/buddy_page_allocator_unit_assert.svh
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bpa_pkg.sv
package bpa_pkg;

  localparam int PAGE_W = 10;
  localparam int ORD_W  = 4;
  localparam int ST_W   = 2;
  localparam int TAG_W  = ORD_W + 1;

  localparam int NUM_ORDERS_DEF = 11;
  localparam int POOL_PAGES_DEF = 1024;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_NO_FREE,
    ST_ORD_BIG,
    ST_TAG_BAD
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_INC,
    OP_SRCH,
    OP_UNLINK,
    OP_SPLIT,
    OP_APP1,
    OP_APP2,
    OP_ATAG,
    OP_FCHK,
    OP_FTAG,
    OP_MRD,
    OP_MERGE,
    OP_FIN,
    OP_RESP
  } dp_op_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ACHK,
    S_SRCH,
    S_UNLINK,
    S_SPLIT,
    S_APP1,
    S_APP2,
    S_ATAG,
    S_FCHK,
    S_FTAG,
    S_MRD,
    S_MTAG,
    S_FIN,
    S_RESP
  } ctl_state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic ord_big;
    logic lvl_top;
    logic head_valid;
    logic split_more;
    logic split_in;
    logic pg_oob;
    logic tag_alloc_ok;
    logic merge_ok;
    logic merge_in;
    logic tag_free_ok;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: src/bpa_req_if.sv
interface bpa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [bpa_pkg::ORD_W-1:0]  block_order;
  logic [bpa_pkg::PAGE_W-1:0] page_number;

  modport source (output valid, cmd, block_order, page_number, input ready);
  modport sink   (input valid, cmd, block_order, page_number, output ready);
endinterface

// File: src/bpa_rsp_if.sv
interface bpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bpa_pkg::ST_W-1:0]   status;
  logic [bpa_pkg::PAGE_W-1:0] alloc_page;

  modport source (output valid, status, alloc_page, input ready);
  modport sink   (input valid, status, alloc_page, output ready);
endinterface

// File: src/bpa_ctl.sv
module bpa_ctl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_free_i,
  input  bpa_pkg::dp_stat_t  stat_i,
  output logic               in_ready_o,
  output bpa_pkg::dp_cmd_t   cmd_o
);
  import bpa_pkg::*;

  ctl_state_e state_q, state_d;
  status_e    st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NOP;
    cmd_o.st   = st_q;
    case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = in_free_i ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat_i.ord_big) begin
          st_d    = ST_ORD_BIG;
          state_d = S_RESP;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat_i.lvl_top) begin
          st_d    = ST_NO_FREE;
          state_d = S_RESP;
        end else if (!stat_i.head_valid) begin
          cmd_o.op = OP_INC;
        end else begin
          cmd_o.op = OP_SRCH;
          state_d  = S_UNLINK;
        end
      end
      S_UNLINK: begin
        cmd_o.op = OP_UNLINK;
        state_d  = S_SPLIT;
      end
      S_SPLIT: begin
        if (!stat_i.split_more) begin
          state_d = S_ATAG;
        end else begin
          cmd_o.op = OP_SPLIT;
          state_d  = stat_i.split_in ? S_APP1 : S_SPLIT;
        end
      end
      S_APP1: begin
        cmd_o.op = OP_APP1;
        state_d  = S_APP2;
      end
      S_APP2: begin
        cmd_o.op = OP_APP2;
        if (stat_i.is_alloc) begin
          state_d = S_SPLIT;
        end else begin
          st_d    = ST_OK;
          state_d = S_RESP;
        end
      end
      S_ATAG: begin
        cmd_o.op = OP_ATAG;
        st_d     = ST_OK;
        state_d  = S_RESP;
      end
      S_FCHK: begin
        if (stat_i.pg_oob) begin
          st_d    = ST_TAG_BAD;
          state_d = S_RESP;
        end else begin
          cmd_o.op = OP_FCHK;
          state_d  = S_FTAG;
        end
      end
      S_FTAG: begin
        if (stat_i.tag_alloc_ok) begin
          cmd_o.op = OP_FTAG;
          state_d  = S_MRD;
        end else begin
          st_d    = ST_TAG_BAD;
          state_d = S_RESP;
        end
      end
      S_MRD: begin
        if (stat_i.merge_ok && stat_i.merge_in) begin
          cmd_o.op = OP_MRD;
          state_d  = S_MTAG;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MTAG: begin
        if (stat_i.tag_free_ok) begin
          cmd_o.op = OP_MERGE;
          state_d  = S_MRD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = S_APP1;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_RESP;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: src/bpa_dp.sv
module bpa_dp #(
  parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF,
  parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bpa_pkg::dp_cmd_t           cmd_i,
  output bpa_pkg::dp_stat_t          stat_o,
  input  logic                       in_cmd_i,
  input  logic [bpa_pkg::ORD_W-1:0]  in_order_i,
  input  logic [bpa_pkg::PAGE_W-1:0] in_page_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [bpa_pkg::ST_W-1:0]   out_status_o,
  output logic [bpa_pkg::PAGE_W-1:0] out_page_o
);
  import bpa_pkg::*;

  localparam int PW   = (POOL_PAGES > 2) ? $clog2(POOL_PAGES) : 1;
  localparam int LW   = $clog2(POOL_PAGES + 1);
  localparam int OIW  = $clog2(NUM_ORDERS);
  localparam int LVW  = $clog2(NUM_ORDERS + 1);
  localparam int BW0  = (LW > NUM_ORDERS) ? LW : NUM_ORDERS;
  localparam int BW   = (BW0 > PAGE_W) ? BW0 : PAGE_W;
  localparam logic [LW-1:0]  NONE   = LW'(POOL_PAGES);
  localparam logic [BW-1:0]  POOL_B = BW'(POOL_PAGES);

  logic [TAG_W-1:0] tag_mem [POOL_PAGES];
  logic [LW-1:0]    nxt_mem [POOL_PAGES];
  logic [LW-1:0]    prv_mem [POOL_PAGES];

  logic [LW-1:0] head_q [NUM_ORDERS];
  logic [LW-1:0] tail_q [NUM_ORDERS];

  logic             is_alloc_q;
  logic [ORD_W-1:0] req_q;
  logic [PAGE_W-1:0] pg_q;
  logic [LVW-1:0]   lvl_q;
  logic [PW-1:0]    p_q, b_q, ap_q, cnt_q;
  logic [TAG_W-1:0] tag_rd_q;
  logic [LW-1:0]    nxt_rd_q, prv_rd_q;
  logic             out_valid_q;
  logic [ST_W-1:0]  out_status_q;
  logic [PAGE_W-1:0] out_page_q;

  logic [OIW-1:0]   lvl_idx;
  logic [LW-1:0]    head_cur, tail_cur;
  logic [BW-1:0]    bm, bs;
  logic             rd_en;
  logic [PW-1:0]    rd_a;
  logic             tag_we, nxt_we, prv_we, hd_we, tl_we;
  logic [PW-1:0]    tag_wa, nxt_wa, prv_wa;
  logic [TAG_W-1:0] tag_wd;
  logic [LW-1:0]    nxt_wd, prv_wd, hd_wd, tl_wd;

  assign lvl_idx  = lvl_q[OIW-1:0];
  assign head_cur = head_q[lvl_idx];
  assign tail_cur = tail_q[lvl_idx];
  assign bm = BW'(p_q) ^ (BW'(1) << lvl_q);
  assign bs = BW'(p_q) ^ (BW'(1) << (lvl_q - LVW'(1)));

  always_comb begin
    stat_o.clr_last     = (cnt_q == PW'(POOL_PAGES - 1));
    stat_o.is_alloc     = is_alloc_q;
    stat_o.ord_big      = ({1'b0, req_q} >= 5'(NUM_ORDERS));
    stat_o.lvl_top      = (5'(lvl_q) >= 5'(NUM_ORDERS));
    stat_o.head_valid   = (head_cur < NONE);
    stat_o.split_more   = (5'(lvl_q) > {1'b0, req_q});
    stat_o.split_in     = (bs < POOL_B);
    stat_o.pg_oob       = (BW'(pg_q) >= POOL_B);
    stat_o.tag_alloc_ok = (tag_rd_q == {1'b1, req_q});
    stat_o.merge_ok     = (5'(lvl_q) < 5'(NUM_ORDERS - 1));
    stat_o.merge_in     = (bm < POOL_B);
    stat_o.tag_free_ok  = (tag_rd_q == {1'b0, ORD_W'(lvl_q)});
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  always_comb begin
    rd_en  = 1'b0;
    rd_a   = p_q;
    tag_we = 1'b0;
    tag_wa = p_q;
    tag_wd = '0;
    nxt_we = 1'b0;
    nxt_wa = ap_q;
    nxt_wd = NONE;
    prv_we = 1'b0;
    prv_wa = ap_q;
    prv_wd = NONE;
    hd_we  = 1'b0;
    hd_wd  = NONE;
    tl_we  = 1'b0;
    tl_wd  = NONE;
    case (cmd_i.op)
      OP_CLR: begin
        tag_we = 1'b1;
        tag_wa = cnt_q;
        tag_wd = (cnt_q == '0) ? {1'b0, ORD_W'(NUM_ORDERS - 1)} : '0;
        nxt_we = (cnt_q == '0);
        nxt_wa = '0;
        prv_we = (cnt_q == '0);
        prv_wa = '0;
      end
      OP_SRCH: begin
        rd_en = 1'b1;
        rd_a  = head_cur[PW-1:0];
      end
      OP_FCHK: begin
        rd_en = 1'b1;
        rd_a  = PW'(pg_q);
      end
      OP_MRD: begin
        rd_en = 1'b1;
        rd_a  = bm[PW-1:0];
      end
      OP_UNLINK, OP_MERGE: begin
        if (prv_rd_q < NONE) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd_q[PW-1:0];
          nxt_wd = nxt_rd_q;
        end else begin
          hd_we = 1'b1;
          hd_wd = nxt_rd_q;
        end
        if (nxt_rd_q < NONE) begin
          prv_we = 1'b1;
          prv_wa = nxt_rd_q[PW-1:0];
          prv_wd = prv_rd_q;
        end else begin
          tl_we = 1'b1;
          tl_wd = prv_rd_q;
        end
        if (cmd_i.op == OP_MERGE) begin
          tag_we = 1'b1;
          tag_wa = b_q;
          tag_wd = '0;
        end
      end
      OP_APP1: begin
        prv_we = 1'b1;
        prv_wd = tail_cur;
        nxt_we = 1'b1;
        nxt_wd = NONE;
        tag_we = 1'b1;
        tag_wa = ap_q;
        tag_wd = {1'b0, ORD_W'(lvl_q)};
      end
      OP_APP2: begin
        if (tail_cur < NONE) begin
          nxt_we = 1'b1;
          nxt_wa = tail_cur[PW-1:0];
          nxt_wd = LW'(ap_q);
        end else begin
          hd_we = 1'b1;
          hd_wd = LW'(ap_q);
        end
        tl_we = 1'b1;
        tl_wd = LW'(ap_q);
      end
      OP_ATAG: begin
        tag_we = 1'b1;
        tag_wd = {1'b1, req_q};
      end
      OP_FTAG: begin
        tag_we = 1'b1;
        tag_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (rd_en) begin
      tag_rd_q <= tag_mem[rd_a];
      nxt_rd_q <= nxt_mem[rd_a];
      prv_rd_q <= prv_mem[rd_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ORDERS; i++) begin
        head_q[i] <= (i == NUM_ORDERS - 1) ? '0 : NONE;
        tail_q[i] <= (i == NUM_ORDERS - 1) ? '0 : NONE;
      end
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (hd_we) head_q[lvl_idx] <= hd_wd;
      if (tl_we) tail_q[lvl_idx] <= tl_wd;
      if (cmd_i.op == OP_CLR) cnt_q <= cnt_q + PW'(1);
      if (cmd_i.op == OP_RESP) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        is_alloc_q <= !in_cmd_i;
        req_q      <= in_order_i;
        pg_q       <= in_page_i;
        lvl_q      <= LVW'(in_order_i);
      end
      OP_INC:   lvl_q <= lvl_q + LVW'(1);
      OP_SRCH:  p_q   <= head_cur[PW-1:0];
      OP_SPLIT: begin
        lvl_q <= lvl_q - LVW'(1);
        ap_q  <= bs[PW-1:0];
      end
      OP_FCHK:  p_q <= PW'(pg_q);
      OP_MRD:   b_q <= bm[PW-1:0];
      OP_MERGE: begin
        lvl_q <= lvl_q + LVW'(1);
        if (b_q < p_q) p_q <= b_q;
      end
      OP_FIN:   ap_q <= p_q;
      OP_RESP: begin
        out_status_q <= cmd_i.st;
        out_page_q   <= (cmd_i.st == ST_OK && is_alloc_q) ? PAGE_W'(p_q) : '0;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_page_o   = out_page_q;

endmodule

// File: src/buddy_page_allocator_unit.sv
// Channel  Dir  Payload                              Transaction when
// req_i    in   cmd, block_order, page_number        valid && ready
// rsp_o    out  status, alloc_page                   valid && ready
//
// One request at a time; ready is high only while the controller is idle.
// Allocate searches the free lists upward from the requested order, then splits the
// block one level at a time down to it; no free block ends the search past the top
// order; order too large is answered without a search; free checks the page's tag,
// then merges one level at a time while the buddy is free; a bad free tag ends it.
// After reset the tag memory is cleared page by page before ready.
// A finished result waits in the output register; the next request is taken meanwhile.

`include "buddy_page_allocator_unit_assert.svh"

module buddy_page_allocator_unit #(
  parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF,
  parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  bpa_req_if.sink    req_i,
  bpa_rsp_if.source  rsp_o
);
  import bpa_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;

  bpa_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_free_i  (req_i.cmd),
    .stat_i     (dp_stat),
    .in_ready_o (in_ready),
    .cmd_o      (dp_cmd)
  );

  bpa_dp #(
    .NUM_ORDERS (NUM_ORDERS),
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_cmd_i     (req_i.cmd),
    .in_order_i   (req_i.block_order),
    .in_page_i    (req_i.page_number),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_status_o (rsp_o.status),
    .out_page_o   (rsp_o.alloc_page)
  );

  assign req_i.ready = in_ready;

  `BPA_ASSERT_NXT(a_one_at_a_time, req_i.valid && req_i.ready, !req_i.ready, "busy accept")
  `BPA_ASSERT_IMP(a_fail_page_zero, rsp_o.valid && rsp_o.status != ST_OK, rsp_o.alloc_page == '0, "page")
  `BPA_ASSERT_IMP(a_clear_blocks, dp_cmd.op == OP_CLR, !req_i.ready, "request taken during clear")

endmodule
